>>> src/cfrd_pkg.sv
package cfrd_pkg;

  localparam int unsigned ONE_Q15   = 32768;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned PIPE_LEN  = 22;
  localparam int unsigned CFG_W     = 31;

  typedef enum logic [0:0] {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [10:0]        hand_index;
    logic signed [31:0] follow_value;
    logic signed [31:0] terminate_value;
    logic               hand_possible;
  } req_t;

  typedef struct packed {
    logic [10:0] result_index;
    logic [15:0] follow_probability;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [10:0] idx;
    logic        possible;
    logic        in_range;
  } ctl_t;

endpackage

>>> src/cfrd_range_reconstruction.sv
// Stages: read, products, expected value, clamp, dividend setup, divider, output.
// Throughput: one request per cycle; a request whose hand is still in the
// pipeline waits (busy) until that hand's strategy is written back.
// Reset: after rst_n a clearing pass of HAND_COUNT cycles initialises the
// regret and strategy memories; busy stays high meanwhile. Results cannot be stalled.
module cfrd_range_reconstruction #(
  parameter int HAND_COUNT = 2048
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  cfrd_pkg::req_t             in_request,
  output logic                       out_strobe,
  output cfrd_pkg::rsp_t             out_result,
  input  logic                       cfg_we,
  input  cfrd_pkg::cfg_reg_t         cfg_index,
  input  logic [cfrd_pkg::CFG_W-1:0] cfg_data
);
  import cfrd_pkg::*;

  localparam int AW = (HAND_COUNT > 1) ? $clog2(HAND_COUNT) : 1;

  logic [63:0] rg_mem [0:HAND_COUNT-1];
  logic [31:0] st_mem [0:HAND_COUNT-1];

  logic [16:0]   floor_r;
  logic [30:0]   ceil_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_cnt_r;
  ctl_t          ctl_r [0:PIPE_LEN-1];

  logic          hit;
  logic          acc;
  logic          in_range;
  logic [AW-1:0] rd_addr;
  ctl_t          ctl_in;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < PIPE_LEN; i++) begin
      if (ctl_r[i].valid && ctl_r[i].idx == in_request.hand_index) begin
        hit = 1'b1;
      end
    end
  end

  assign busy     = clr_active_r || hit;
  assign acc      = start && !busy;
  assign in_range = {21'd0, in_request.hand_index} < 32'(HAND_COUNT);
  assign rd_addr  = AW'(in_request.hand_index);
  assign ctl_in   = '{valid: acc, idx: in_request.hand_index,
                      possible: in_request.hand_possible, in_range: in_range};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= 17'd1;
      ceil_r  <= 31'h7FFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLOOR:   floor_r <= cfg_data[16:0];
        REG_CEILING: ceil_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(HAND_COUNT - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LEN; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < PIPE_LEN; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // stage 1: memory read
  logic [63:0]        rg_rd_r;
  logic [31:0]        st_rd_r;
  logic signed [31:0] fv1_r, tv1_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      rg_rd_r <= rg_mem[rd_addr];
      st_rd_r <= st_mem[rd_addr];
      fv1_r   <= in_request.follow_value;
      tv1_r   <= in_request.terminate_value;
    end
  end

  // stage 2: products
  logic signed [48:0] pf_r, pt_r, pf_nxt, pt_nxt;
  logic signed [31:0] fv2_r, tv2_r;
  logic [31:0]        fr2_r, sr2_r;

  assign pf_nxt = fv1_r * $signed({1'b0, st_rd_r[31:16]});
  assign pt_nxt = tv1_r * $signed({1'b0, st_rd_r[15:0]});

  always_ff @(posedge clk) begin
    pf_r  <= pf_nxt;
    pt_r  <= pt_nxt;
    fv2_r <= fv1_r;
    tv2_r <= tv1_r;
    fr2_r <= rg_rd_r[63:32];
    sr2_r <= rg_rd_r[31:0];
  end

  // stage 3: expected value
  logic signed [49:0] psum;
  logic signed [34:0] ev_r, ev_nxt;
  logic signed [31:0] fv3_r, tv3_r;
  logic [31:0]        fr3_r, sr3_r;

  assign psum   = 50'(pf_r) + 50'(pt_r) + 50'sd16384;
  assign ev_nxt = 35'(psum >>> 15);

  always_ff @(posedge clk) begin
    ev_r  <= ev_nxt;
    fv3_r <= fv2_r;
    tv3_r <= tv2_r;
    fr3_r <= fr2_r;
    sr3_r <= sr2_r;
  end

  // stage 4: accumulate and clamp
  logic signed [35:0] raw_f, raw_s, floor_s, ceil_s, cf_a, cs_a;
  logic [30:0]        fr4_r, sr4_r;

  assign floor_s = $signed({19'd0, floor_r});
  assign ceil_s  = $signed({5'd0, ceil_r});
  assign raw_f   = $signed({4'd0, fr3_r}) + 36'(fv3_r) - 36'(ev_r);
  assign raw_s   = $signed({4'd0, sr3_r}) + 36'(tv3_r) - 36'(ev_r);

  always_comb begin
    cf_a = (raw_f < floor_s) ? floor_s : raw_f;
    cs_a = (raw_s < floor_s) ? floor_s : raw_s;
    if (cf_a > ceil_s) begin
      cf_a = ceil_s;
    end
    if (cs_a > ceil_s) begin
      cs_a = ceil_s;
    end
  end

  always_ff @(posedge clk) begin
    fr4_r <= cf_a[30:0];
    sr4_r <= cs_a[30:0];
  end

  // stage 5: dividend setup
  logic [32:0] sum5_r, sum_nxt;
  logic [48:0] df5_r, ds5_r;
  logic        zero5_r;

  assign sum_nxt = {2'd0, fr4_r} + {2'd0, sr4_r};

  always_ff @(posedge clk) begin
    sum5_r  <= sum_nxt;
    zero5_r <= (sum_nxt == '0);
    df5_r   <= {3'd0, fr4_r, 15'd0} + {17'd0, sum_nxt[32:1]};
    ds5_r   <= {3'd0, sr4_r, 15'd0} + {17'd0, sum_nxt[32:1]};
  end

  // restoring divider, one quotient bit per stage
  logic [48:0] rf_r  [0:DIV_STEPS-1];
  logic [48:0] rs_r  [0:DIV_STEPS-1];
  logic [15:0] qf_r  [0:DIV_STEPS-1];
  logic [15:0] qs_r  [0:DIV_STEPS-1];
  logic [32:0] sum_r [0:DIV_STEPS-1];
  logic        zr_r  [0:DIV_STEPS-1];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [48:0] rf_in, rs_in, dsh;
    logic [15:0] qf_in, qs_in, qf_nxt, qs_nxt;
    logic [32:0] sum_in;
    logic        z_in, gf, gs;

    if (j == 0) begin : g_first
      assign rf_in  = df5_r;
      assign rs_in  = ds5_r;
      assign qf_in  = '0;
      assign qs_in  = '0;
      assign sum_in = sum5_r;
      assign z_in   = zero5_r;
    end else begin : g_next
      assign rf_in  = rf_r[j-1];
      assign rs_in  = rs_r[j-1];
      assign qf_in  = qf_r[j-1];
      assign qs_in  = qs_r[j-1];
      assign sum_in = sum_r[j-1];
      assign z_in   = zr_r[j-1];
    end

    assign dsh = {16'd0, sum_in} << (DIV_STEPS - 1 - j);
    assign gf  = rf_in >= dsh;
    assign gs  = rs_in >= dsh;

    always_comb begin
      qf_nxt = qf_in;
      qs_nxt = qs_in;
      qf_nxt[DIV_STEPS-1-j] = gf;
      qs_nxt[DIV_STEPS-1-j] = gs;
    end

    always_ff @(posedge clk) begin
      rf_r[j]  <= gf ? rf_in - dsh : rf_in;
      rs_r[j]  <= gs ? rs_in - dsh : rs_in;
      qf_r[j]  <= qf_nxt;
      qs_r[j]  <= qs_nxt;
      sum_r[j] <= sum_in;
      zr_r[j]  <= z_in;
    end
  end

  // output stage
  ctl_t        ctl_last;
  logic [15:0] fs_nxt, ss_nxt, fs_r, ss_r;

  assign ctl_last = ctl_r[PIPE_LEN-2];

  always_comb begin
    if (zr_r[DIV_STEPS-1]) begin
      fs_nxt = '0;
      ss_nxt = 16'(ONE_Q15);
    end else begin
      fs_nxt = (qf_r[DIV_STEPS-1] > 16'(ONE_Q15)) ? 16'(ONE_Q15) : qf_r[DIV_STEPS-1];
      ss_nxt = (qs_r[DIV_STEPS-1] > 16'(ONE_Q15)) ? 16'(ONE_Q15) : qs_r[DIV_STEPS-1];
    end
    if (!ctl_last.possible || !ctl_last.in_range) begin
      fs_nxt = '0;
      ss_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    fs_r <= fs_nxt;
    ss_r <= ss_nxt;
  end

  assign out_strobe                    = ctl_r[PIPE_LEN-1].valid;
  assign out_result.result_index       = ctl_r[PIPE_LEN-1].idx;
  assign out_result.follow_probability = fs_r;

  // memory write ports
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      rg_mem[clr_cnt_r] <= '0;
    end else if (ctl_r[3].valid && ctl_r[3].in_range) begin
      rg_mem[AW'(ctl_r[3].idx)] <= {1'b0, fr4_r, 1'b0, sr4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      st_mem[clr_cnt_r] <= {16'd0, 16'(ONE_Q15)};
    end else if (ctl_r[PIPE_LEN-1].valid && ctl_r[PIPE_LEN-1].in_range) begin
      st_mem[AW'(ctl_r[PIPE_LEN-1].idx)] <= {fs_r, ss_r};
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##22 (out_strobe && out_result.result_index == $past(in_request.hand_index, 22)))
    else $error("result missing or misplaced");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !ctl_r[3].valid && !ctl_r[PIPE_LEN-1].valid)
    else $error("pipeline write during clearing pass");

  a_prob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_result.follow_probability <= 16'(ONE_Q15))
    else $error("probability above one");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cfrd_pkg::*;

  localparam int HANDS = 2048;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES = 5;
  localparam int DRAIN_CYCLES = PIPE_LEN + 8;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_request;
  logic out_strobe;
  rsp_t out_result;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  logic typed_valid;
  logic [15:0] typed_prob;

  typedef struct {
    req_t r;
    bit typed;
    logic [15:0] prob;
  } stim_row_t;

  logic [31:0] follow_regret_q[HANDS];
  logic [31:0] stop_regret_q[HANDS];
  logic [15:0] follow_strat_q[HANDS];
  logic [15:0] stop_strat_q[HANDS];
  longint floor_q;
  longint ceiling_q;

  rsp_t pending_results[$];
  bit failed;

  cfrd_range_reconstruction dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_request(in_request),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint clip_regret(input longint v);
    longint c;
    c = v;
    if (c < floor_q) c = floor_q;
    if (c > ceiling_q) c = ceiling_q;
    return c;
  endfunction

  function automatic logic [15:0] strategy_share(input longint unsigned part,
                                                 input longint unsigned total);
    longint unsigned q;
    q = (part * 64'd32768 + total / 2) / total;
    if (q > ONE_Q15) q = ONE_Q15;
    return q[15:0];
  endfunction

  function automatic logic [15:0] update_hand(input req_t r);
    int h;
    longint fv;
    longint tv;
    longint ev;
    longint unsigned fr;
    longint unsigned sr;
    longint unsigned total;
    logic [15:0] fs;
    logic [15:0] ss;
    h = r.hand_index;
    fv = longint'($signed(r.follow_value));
    tv = longint'($signed(r.terminate_value));
    ev = fv * longint'(follow_strat_q[h]) + tv * longint'(stop_strat_q[h]);
    ev = (ev + 16384) >>> 15;
    fr = clip_regret(longint'(follow_regret_q[h]) + fv - ev);
    sr = clip_regret(longint'(stop_regret_q[h]) + tv - ev);
    follow_regret_q[h] = fr[31:0];
    stop_regret_q[h] = sr[31:0];
    total = fr + sr;
    if (total == 0) begin
      fs = 16'd0;
      ss = 16'(ONE_Q15);
    end else begin
      fs = strategy_share(fr, total);
      ss = strategy_share(sr, total);
    end
    if (!r.hand_possible) begin
      fs = 16'd0;
      ss = 16'd0;
    end
    follow_strat_q[h] = fs;
    stop_strat_q[h] = ss;
    return fs;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && start && !busy) begin
      e.result_index = in_request.hand_index;
      e.follow_probability = update_hand(in_request);
      if (typed_valid) e.follow_probability = typed_prob;
      pending_results.push_back(e);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_result);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_result.result_index !== e.result_index) begin
          $display("%0t: result_index expected %0d actual %0d", $time,
                   e.result_index, out_result.result_index);
          failed = 1'b1;
        end
        if (out_result.follow_probability !== e.follow_probability) begin
          $display("%0t: follow_probability expected %0d actual %0d", $time,
                   e.follow_probability, out_result.follow_probability);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input longint unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    if (idx == REG_FLOOR) floor_q = value & 64'h1ffff;
    else ceiling_q = value & 64'h7fffffff;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    wait (pending_results.size() == 0);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_request(input req_t r, input bit typed, input logic [15:0] prob);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_request <= r;
    typed_valid <= typed;
    typed_prob <= prob;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.hand_index = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, HANDS - 1))
                                               : 11'($urandom_range(0, 15));
    r.follow_value = pick_value();
    r.terminate_value = pick_value();
    r.hand_possible = ($urandom_range(0, 4) != 0);
    return r;
  endfunction

  task automatic set_phase(input int p);
    case (p)
      1: begin
        write_reg(REG_FLOOR, 65536);
        write_reg(REG_CEILING, 1);
      end
      2: begin
        write_reg(REG_FLOOR, 1);
        write_reg(REG_CEILING, 1000);
      end
      3: begin
        write_reg(REG_FLOOR, $urandom_range(1, 65536));
        write_reg(REG_CEILING, $urandom_range(65536, 32'h7fffffff));
      end
      default: begin
        write_reg(REG_FLOOR, 1);
        write_reg(REG_CEILING, 32'h7fffffff);
      end
    endcase
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    for (int i = 0; i < HANDS; i++) begin
      follow_regret_q[i] = '0;
      stop_regret_q[i] = '0;
      follow_strat_q[i] = '0;
      stop_strat_q[i] = 16'(ONE_Q15);
    end
    floor_q = 1;
    ceiling_q = 32'h7fffffff;
    failed = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_request = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FLOOR;
    cfg_data = '0;
    typed_valid = 1'b0;
    typed_prob = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    rows.push_back('{'{11'd0, 32'sd0, 32'sd0, 1'b1}, 1'b1, 16'd16384});
    rows.push_back('{'{11'd1, 32'sh7fffffff, 32'sh80000000, 1'b0}, 1'b1, 16'd0});
    rows.push_back('{'{11'd2047, 32'sh7fffffff, 32'sh80000000, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd2047, 32'sh7fffffff, 32'sh80000000, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd5, 32'sh80000000, 32'sh7fffffff, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd5, 32'sh80000000, 32'sh7fffffff, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd5, 32'sh00010000, 32'sh00008000, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd5, 32'sh7fffffff, 32'sh7fffffff, 1'b0}, 1'b1, 16'd0});
    rows.push_back('{'{11'd5, 32'shffff0000, 32'sh00010000, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd3, 32'shffffffff, 32'shffffffff, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd1024, 32'sh55555555, 32'shaaaaaaaa, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd1024, 32'shaaaaaaaa, 32'sh55555555, 1'b1}, 1'b0, 16'd0});
    rows.push_back('{'{11'd1365, 32'sh00000001, 32'sh00000000, 1'b1}, 1'b0, 16'd0});
    foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].prob);
    start <= 1'b0;
    drain();

    set_phase(1);
    row = '{'{11'd9, 32'sh7fffffff, 32'sh80000000, 1'b1}, 1'b1, 16'd16384};
    send_request(row.r, row.typed, row.prob);
    row = '{'{11'd9, 32'sh80000000, 32'sh7fffffff, 1'b0}, 1'b1, 16'd0};
    send_request(row.r, row.typed, row.prob);
    start <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_phase(p);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
        send_request(random_request(), 1'b0, 16'd0);
      start <= 1'b0;
      drain();
    end

    if (failed || pending_results.size() != 0) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end

endmodule

>>> cfrd_range_reconstruction.f
src/cfrd_pkg.sv
src/cfrd_range_reconstruction.sv
dv/testbench.sv
